### rtl/adcdc_pkg.sv
// Package: shared constants, register indexes and controller/datapath interface types.
`timescale 1ns / 1ps
package adcdc_pkg;

  localparam int SAMPLES_PER_PACKET = 256;
  localparam int PKT_W = (SAMPLES_PER_PACKET > 1) ? $clog2(SAMPLES_PER_PACKET) : 1;
  localparam logic [PKT_W-1:0] PKT_LAST = PKT_W'(SAMPLES_PER_PACKET - 1);

  localparam logic [11:0] CODE_MID = 12'd2048;
  localparam logic [15:0] COEFF_MAX = 16'd65529;
  localparam logic [15:0] COEFF_RESET = 16'd65331;
  localparam logic [15:0] GAIN_RESET = 16'd256;
  localparam logic signed [25:0] FILT_LIMIT = 26'sd4194304;
  localparam logic signed [29:0] PCM_LIMIT = 30'sd32734;
  localparam logic signed [57:0] ROUND_HALF = 58'sd134217728;

  typedef enum logic [0:0] {
    CFG_FEEDBACK_COEFF = 1'b0,
    CFG_RECORD_GAIN    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic capture;
    logic filter;
    logic gain;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

### rtl/adcdc_ctrl.sv
// Controller: sequences capture, filter update, gain product and output load per sample.
`timescale 1ns / 1ps
module adcdc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  adcdc_pkg::sts_t sts_i,
  output adcdc_pkg::cmd_t cmd_o
);
  import adcdc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FILT = 4'b0010,
    S_GAIN = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_FILT;
        end
      end
      S_FILT: begin
        cmd_o.filter = 1'b1;
        state_d = S_GAIN;
      end
      S_GAIN: begin
        cmd_o.gain = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/adcdc_dp.sv
// Datapath: config registers, shared multiplier, DC-blocking filter state and PCM output stage.
`timescale 1ns / 1ps
module adcdc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  adcdc_pkg::cfg_idx_e cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic [7:0]          reply_high_i,
  input  logic [7:0]          reply_low_i,
  input  logic                transfer_failed_i,
  input  adcdc_pkg::cmd_t     cmd_i,
  output adcdc_pkg::sts_t     sts_o,
  output logic signed [15:0]  pcm_sample_o,
  output logic                packet_end_o,
  output logic                out_valid_o,
  input  logic                out_ready_i
);
  import adcdc_pkg::*;

  logic [15:0] coeff_q, gain_q;
  logic signed [12:0] c_q, pin_q;
  logic signed [23:0] yprev_q;
  logic signed [40:0] prod_q;
  logic [PKT_W-1:0] pos_q;
  logic signed [15:0] out_data_q;
  logic out_last_q, out_valid_q;

  logic [11:0] code;
  logic signed [12:0] c_new;
  logic signed [16:0] mul_b;
  logic signed [40:0] mul_p;
  logic signed [40:0] fb_full;
  logic signed [13:0] diff;
  logic signed [25:0] y_raw;
  logic signed [23:0] y_sat;
  logic signed [57:0] acc;
  logic signed [29:0] sh;
  logic signed [15:0] pcm;

  assign code  = transfer_failed_i ? CODE_MID : {reply_high_i[4:0], reply_low_i[7:1]};
  assign c_new = $signed({1'b0, code}) - $signed({1'b0, CODE_MID});

  assign mul_b = cmd_i.capture ? $signed({1'b0, coeff_q}) : $signed({1'b0, gain_q});
  assign mul_p = yprev_q * mul_b;

  assign fb_full = (prod_q + 41'sd32768) >>> 16;
  assign diff    = 14'(c_q) - 14'(pin_q);
  assign y_raw   = 26'($signed(fb_full[24:0])) + 26'($signed({diff, 9'd0}));

  always_comb begin
    if (y_raw > FILT_LIMIT) begin
      y_sat = 24'(FILT_LIMIT);
    end else if (y_raw < -FILT_LIMIT) begin
      y_sat = 24'(-FILT_LIMIT);
    end else begin
      y_sat = y_raw[23:0];
    end
  end

  assign acc = (58'(prod_q) <<< 15) - 58'(prod_q) + ROUND_HALF;
  assign sh  = acc[57:28];

  always_comb begin
    if (sh > PCM_LIMIT) begin
      pcm = 16'(PCM_LIMIT);
    end else if (sh < -PCM_LIMIT) begin
      pcm = 16'(-PCM_LIMIT);
    end else begin
      pcm = sh[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= COEFF_RESET;
      gain_q  <= GAIN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FEEDBACK_COEFF: coeff_q <= (cfg_data_i > COEFF_MAX) ? COEFF_MAX : cfg_data_i;
        CFG_RECORD_GAIN:    gain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q       <= '0;
      yprev_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.filter) begin
        pin_q   <= c_q;
        yprev_q <= y_sat;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        pos_q <= (pos_q == PKT_LAST) ? '0 : pos_q + 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      c_q <= c_new;
    end
    if (cmd_i.capture || cmd_i.gain) begin
      prod_q <= mul_p;
    end
    if (cmd_i.emit) begin
      out_data_q <= pcm;
      out_last_q <= (pos_q == PKT_LAST);
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign pcm_sample_o   = out_data_q;
  assign packet_end_o   = out_last_q;
  assign out_valid_o    = out_valid_q;

endmodule

### rtl/adc_dc_block_gain_to_pcm16.sv
// Top level: 12-bit ADC reply to DC-blocked, gained, clamped 16-bit PCM stream.
`timescale 1ns / 1ps
// Each input word carries the two ADC reply bytes and a failed-transfer flag; each output
// word carries one signed 16-bit PCM sample, with tlast closing every 256-sample packet.
// A sample steps through the controller states and the one multiplier is used twice: the
// accept cycle forms the pole feedback product, the filter state updates the filter, the
// gain state forms the gain product, and the output state scales, rounds, clamps and loads
// the output register. A stall holds the output state; the next input word is taken
// in the cycle after the previous result has entered the output register. Configuration
// writes (index 0: pole in Q0.16, saturated to 65529; index 1: gain in Q8.8) are taken at
// any time with cfg_ready_o always high, and belong between samples.
module adc_dc_block_gain_to_pcm16 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // reply_high [7:0], reply_low [15:8]
  input  logic                s_axis_tuser,   // transfer_failed
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // pcm_sample [15:0]
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  adcdc_pkg::cfg_idx_e cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import adcdc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic signed [15:0] pcm_sample;

  assign cfg_ready_o = 1'b1;

  adcdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  adcdc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .reply_high_i      (s_axis_tdata[7:0]),
    .reply_low_i       (s_axis_tdata[15:8]),
    .transfer_failed_i (s_axis_tuser),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .pcm_sample_o      (pcm_sample),
    .packet_end_o      (m_axis_tlast),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready)
  );

  assign m_axis_tdata = pcm_sample;

  a_pcm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pcm_sample <= 16'sd32734 && pcm_sample >= -16'sd32734))
    else $error("pcm sample outside clamp range");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken while a sample is in work");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> m_axis_tvalid)
    else $error("output load did not raise tvalid");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

endmodule
